/* src/vlma_pkg.sv */
package vlma_pkg;

    // default lane count and depth of the queue between front and back
    localparam int LANE_COUNT_DEF = 8;
    localparam int QUEUE_DEPTH    = 2;

    // operation codes of req_type
    localparam logic [3:0] OP_MULF = 4'd0;
    localparam logic [3:0] OP_MULU = 4'd1;
    localparam logic [3:0] OP_MUDL = 4'd2;
    localparam logic [3:0] OP_MUDM = 4'd3;
    localparam logic [3:0] OP_MUDN = 4'd4;
    localparam logic [3:0] OP_MUDH = 4'd5;
    localparam logic [3:0] OP_MACF = 4'd6;
    localparam logic [3:0] OP_MACU = 4'd7;
    localparam logic [3:0] OP_MADL = 4'd8;
    localparam logic [3:0] OP_MADM = 4'd9;
    localparam logic [3:0] OP_MADN = 4'd10;
    localparam logic [3:0] OP_MADH = 4'd11;

    // product form, shared by the replace and accumulate variants
    typedef enum logic [2:0] {
        KIND_F,
        KIND_FU,
        KIND_L,
        KIND_M,
        KIND_N,
        KIND_H
    } kind_t;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [2:0]  lane;
        logic [15:0] vs_value;
        logic [15:0] vt_value;
    } req_word_t;

    typedef struct packed {
        logic [15:0]        lane_result;
        logic signed [47:0] acc_value;
    } rsp_word_t;

    // classified word handed from front to back
    typedef struct packed {
        kind_t              kind;
        logic               accumulate;
        logic               op_ok;
        logic               lane_ok;
        logic [2:0]         lane;
        logic signed [33:0] product;
    } work_t;

endpackage

/* src/vlma_front.sv */
module vlma_front
    import vlma_pkg::*;
#(
    parameter int LANE_COUNT = LANE_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req,
    output logic      work_valid,
    input  logic      work_room,
    output work_t     work
);

    work_t work_reg;
    work_t work_next;
    logic  work_valid_reg;
    logic  push;
    logic  a_signed;
    logic  b_signed;
    logic signed [16:0] op_a;
    logic signed [16:0] op_b;

    // decode the operation into product form and replace/accumulate
    always_comb
    begin
        work_next            = '0;
        work_next.op_ok      = 1'b1;
        work_next.accumulate = 1'b0;
        work_next.kind       = KIND_L;
        case (req.req_type)
            OP_MULF: work_next.kind = KIND_F;
            OP_MULU: work_next.kind = KIND_FU;
            OP_MUDL: work_next.kind = KIND_L;
            OP_MUDM: work_next.kind = KIND_M;
            OP_MUDN: work_next.kind = KIND_N;
            OP_MUDH: work_next.kind = KIND_H;
            OP_MACF:
            begin
                work_next.kind       = KIND_F;
                work_next.accumulate = 1'b1;
            end
            OP_MACU:
            begin
                work_next.kind       = KIND_FU;
                work_next.accumulate = 1'b1;
            end
            OP_MADL:
            begin
                work_next.kind       = KIND_L;
                work_next.accumulate = 1'b1;
            end
            OP_MADM:
            begin
                work_next.kind       = KIND_M;
                work_next.accumulate = 1'b1;
            end
            OP_MADN:
            begin
                work_next.kind       = KIND_N;
                work_next.accumulate = 1'b1;
            end
            OP_MADH:
            begin
                work_next.kind       = KIND_H;
                work_next.accumulate = 1'b1;
            end
            default: work_next.op_ok = 1'b0;
        endcase

        a_signed = (work_next.kind != KIND_L) && (work_next.kind != KIND_N);
        b_signed = (work_next.kind != KIND_L) && (work_next.kind != KIND_M);
        op_a     = {a_signed & req.vs_value[15], req.vs_value};
        op_b     = {b_signed & req.vt_value[15], req.vt_value};

        work_next.product = 34'(op_a) * 34'(op_b);
        work_next.lane    = req.lane;
        work_next.lane_ok = ({2'b00, req.lane} < 5'(LANE_COUNT));
    end

    // one register stage after the multiplier
    assign push      = work_valid_reg && work_room;
    assign req_ready = !work_valid_reg || work_room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
        end
        else if (req_valid && req_ready)
        begin
            work_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            work_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            work_reg <= work_next;
        end
    end

    assign work_valid = work_valid_reg;
    assign work       = work_reg;

endmodule

/* src/vlma_queue.sv */
module vlma_queue
    import vlma_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_word,
    output logic  room,
    input  logic  pop,
    output logic  head_valid,
    output work_t head
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    work_t           slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign room       = (count_reg != CntW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && room;
    assign do_pop     = pop && head_valid;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

/* src/vlma_back.sv */
module vlma_back
    import vlma_pkg::*;
#(
    parameter int LANE_COUNT = LANE_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  work_t     head,
    output logic      pop,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp
);

    // the 3-bit lane field reaches at most eight accumulators
    localparam int StoreDepth = (LANE_COUNT < 8) ? LANE_COUNT : 8;
    localparam int IdxW       = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

    logic [47:0]     acc_reg [StoreDepth];
    rsp_word_t       rsp_reg;
    rsp_word_t       rsp_next;
    logic            rsp_valid_reg;
    logic [IdxW-1:0] idx;
    logic [47:0]     acc_cur;
    logic [47:0]     shaped;
    logic [47:0]     base;
    logic [47:0]     sum;
    logic            rounding;
    logic            write_en;
    logic            sat_s;
    logic            sat_u;
    logic [15:0]     clamped;

    assign pop = head_valid && (!rsp_valid_reg || rsp_ready);
    assign idx = head.lane[IdxW-1:0];

    // align the product, then one 48-bit add into the accumulator
    always_comb
    begin
        acc_cur = head.lane_ok ? acc_reg[idx] : '0;
        case (head.kind)
            KIND_F, KIND_FU: shaped = {{13{head.product[33]}}, head.product, 1'b0};
            KIND_L:          shaped = {32'd0, head.product[31:16]};
            KIND_M, KIND_N:  shaped = {{14{head.product[33]}}, head.product};
            KIND_H:          shaped = {head.product[31:0], 16'd0};
            default:         shaped = '0;
        endcase

        rounding = !head.accumulate && ((head.kind == KIND_F) || (head.kind == KIND_FU));
        if (head.accumulate)
        begin
            base = acc_cur;
        end
        else if (rounding)
        begin
            base = 48'h8000;
        end
        else
        begin
            base = '0;
        end
        sum = base + shaped;

        // bits 47..16 fit in 16 signed bits only when 47..31 agree
        sat_s = (sum[47:31] != '0) && (sum[47:31] != '1);
        sat_u = (sum[46:31] != '0);
        case (head.kind)
            KIND_FU:
            begin
                if (sum[47])
                begin
                    clamped = 16'h0000;
                end
                else if (sat_u)
                begin
                    clamped = 16'hFFFF;
                end
                else
                begin
                    clamped = sum[31:16];
                end
            end
            KIND_L, KIND_N: clamped = sum[15:0];
            default:
            begin
                if (sat_s)
                begin
                    clamped = sum[47] ? 16'h8000 : 16'h7FFF;
                end
                else
                begin
                    clamped = sum[31:16];
                end
            end
        endcase

        write_en = pop && head.lane_ok && head.op_ok;

        // out-of-range lane gives zeros, unknown operation the old value
        rsp_next = '0;
        if (head.lane_ok && head.op_ok)
        begin
            rsp_next.lane_result = clamped;
            rsp_next.acc_value   = sum;
        end
        else if (head.lane_ok)
        begin
            rsp_next.acc_value = acc_cur;
        end
    end

    // lane accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < StoreDepth; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < StoreDepth; i++)
            begin
                if (write_en && (idx == IdxW'(i)))
                begin
                    acc_reg[i] <= sum;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* src/vector_lane_multiply_accumulate.sv */
// Per-lane 48-bit multiply-accumulate. Each request word carries an operation,
// a lane and two raw 16-bit elements, and gives one response word: the lane's
// new accumulator and the clamped (or low) 16-bit element. One word is taken
// per cycle while responses are taken; a response held back by a low rsp_ready
// stalls the back end and, once the queue fills, drops req_ready. A word passes
// the front register behind the 17x17 multiplier, the two-entry queue, then the
// output register. The sustained rate of one word per cycle is set by the back
// end's read-add-write of the lane accumulator. Accumulators clear to zero at
// reset; a lane at or above LANE_COUNT, or an unknown operation, leaves them untouched.
module vector_lane_multiply_accumulate
    import vlma_pkg::*;
#(
    parameter int LANE_COUNT = LANE_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp
);

    logic  work_valid;
    logic  work_room;
    work_t work;
    logic  pop;
    logic  head_valid;
    work_t head;

    // decode and multiply
    vlma_front #(
        .LANE_COUNT(LANE_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .work_valid(work_valid),
        .work_room (work_room),
        .work      (work)
    );

    // decoupling queue
    vlma_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (work_valid),
        .push_word (work),
        .room      (work_room),
        .pop       (pop),
        .head_valid(head_valid),
        .head      (head)
    );

    // accumulate, clamp and respond
    vlma_back #(
        .LANE_COUNT(LANE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
